// ===== rtl/scfla_pkg.sv =====
// Shared types and constants for the size-class free-list allocator.
// Holds field widths, default parameter values, status codes and the
// command/status structs between the controller and the datapath.
package scfla_pkg;

  // Field widths
  localparam int OP_W  = 1;
  localparam int REQ_W = 12;
  localparam int OFF_W = 16;
  localparam int ST_W  = 2;
  localparam int EP_W  = 17;

  // Link words are indexed by offset / 4
  localparam int WIDX_W = OFF_W - 2;

  localparam int HEADER_BYTES = 256;

  // Parameter defaults
  localparam int ALIGN_BYTES_DEF     = 4;
  localparam int MAX_CHUNK_BYTES_DEF = 256;
  localparam int ARENA_BYTES_DEF     = 65536;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch input transaction
    logic decode;    // compute class, read list head
    logic exec;      // latch result of the request
    logic link_rd;   // read link word of list head
    logic push;      // free: write link word and new head
    logic bump;      // allocate from the end pointer
    logic pop_wr;    // write popped link into list head
    logic load_out;  // move result into output register
  } cmd_t;

  // Datapath to controller, valid in the execute cycle
  typedef struct packed {
    logic too_large;
    logic is_free;
    logic head_empty;
    logic full;
    logic chunk_zero;
  } sts_t;

endpackage

// ===== rtl/scfla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scfla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/scfla_ctrl.sv =====
// Controller state machine of the allocator: sequences decode, execute,
// link pop and result hand-off. Uses scfla_pkg command/status structs.
module scfla_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  scfla_pkg::sts_t sts,
  output scfla_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_POP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_DONE;
        priority if (sts.too_large) begin
          // nothing changes
        end else if (!sts.is_free) begin
          if (!sts.head_empty) begin
            cmd.link_rd = 1'b1;
            state_nxt   = S_POP;
          end else if (!sts.full) begin
            cmd.bump = 1'b1;
          end
        end else if (!sts.chunk_zero) begin
          cmd.push = 1'b1;
        end
      end
      S_POP: begin
        cmd.pop_wr = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/scfla_dp.sv =====
// Datapath of the allocator: request registers, size-class decode,
// list-head and link-word RAMs, end pointer and result registers.
// Depends on scfla_pkg and scfla_ram.
module scfla_dp #(
  parameter int ALIGN_BYTES     = scfla_pkg::ALIGN_BYTES_DEF,
  parameter int MAX_CHUNK_BYTES = scfla_pkg::MAX_CHUNK_BYTES_DEF,
  parameter int ARENA_BYTES     = scfla_pkg::ARENA_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scfla_pkg::cmd_t               cmd,
  output scfla_pkg::sts_t               sts,
  input  logic [scfla_pkg::OP_W-1:0]    in_op,
  input  logic [scfla_pkg::REQ_W-1:0]   in_req_size,
  input  logic [scfla_pkg::OFF_W-1:0]   in_chunk_offset,
  output logic [scfla_pkg::OFF_W-1:0]   out_result_offset,
  output logic [scfla_pkg::ST_W-1:0]    out_status
);

  localparam int NUM_CHAINS  = (MAX_CHUNK_BYTES - ALIGN_BYTES) / ALIGN_BYTES;
  localparam int HEAD_DEPTH  = (NUM_CHAINS < 1) ? 1 : NUM_CHAINS;
  localparam int CLS_W       = (HEAD_DEPTH > 1) ? $clog2(HEAD_DEPTH) : 1;
  localparam int MAX_ROUNDED = NUM_CHAINS * ALIGN_BYTES;
  localparam int X_W         = $clog2(MAX_CHUNK_BYTES);
  // cls = (size - 1) / ALIGN_BYTES via reciprocal, exact for x < 2**X_W
  localparam int RECIP_S     = X_W + $clog2(ALIGN_BYTES) + 1;
  localparam int RECIP_M     = ((1 << RECIP_S) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int PROD_W      = X_W + RECIP_S;
  localparam int RND_W       = X_W + 1;
  localparam int LINK_WORDS  = ARENA_BYTES / 4;
  localparam int LINK_AW     = $clog2(LINK_WORDS);
  localparam int QSTEPS      = $clog2((1 << scfla_pkg::WIDX_W) / LINK_WORDS) + 1;
  localparam int CMP_W       = scfla_pkg::WIDX_W + QSTEPS;
  localparam int EP_W        = scfla_pkg::EP_W;
  localparam int OFF_W       = scfla_pkg::OFF_W;
  localparam int REQ_W       = scfla_pkg::REQ_W;

  // Request registers
  logic [scfla_pkg::OP_W-1:0] op_r;
  logic [REQ_W-1:0]           size_r;
  logic [OFF_W-1:0]           chunk_r;

  // Decode
  logic [X_W-1:0]    dec_x;
  logic [PROD_W-1:0] dec_prod;
  logic [CLS_W-1:0]  dec_cls;
  logic              dec_too_large;
  logic [CLS_W-1:0]  cls_r;
  logic              too_large_r;

  // Execute
  logic [(1 << CLS_W)-1:0] head_vld_r;
  logic [OFF_W-1:0]        head_rdata;
  logic [OFF_W-1:0]        head_val;
  logic [RND_W-1:0]        rnd_units;
  logic [RND_W-1:0]        rounded;
  logic [EP_W-1:0]         end_ptr_r;
  logic [EP_W-1:0]         ep_sum;
  logic                    full;
  logic [OFF_W-1:0]        link_src;
  logic [CMP_W-1:0]        widx_v;
  logic [LINK_AW-1:0]      link_idx;
  logic [OFF_W-1:0]        link_rdata;
  logic                    head_we;
  logic [OFF_W-1:0]        head_wdata;

  // Result
  logic [OFF_W-1:0]        res_off_nxt, res_off_r;
  scfla_pkg::status_t      res_st_nxt, res_st_r;
  logic [OFF_W-1:0]        out_off_r;
  scfla_pkg::status_t      out_st_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      size_r  <= in_req_size;
      chunk_r <= in_chunk_offset;
    end
  end

  // Size-class decode
  assign dec_x    = (size_r == '0) ? '0 : X_W'(size_r - REQ_W'(1));
  assign dec_prod = PROD_W'(dec_x) * PROD_W'(RECIP_M);
  assign dec_cls  = dec_prod[RECIP_S +: CLS_W];
  assign dec_too_large = (size_r == '0) ? (ALIGN_BYTES > MAX_ROUNDED)
                                        : ({1'b0, size_r} > (REQ_W+1)'(MAX_ROUNDED));

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      cls_r       <= dec_cls;
      too_large_r <= dec_too_large;
    end
  end

  // Entries never written read as an empty list
  assign head_val  = head_vld_r[cls_r] ? head_rdata : '0;
  assign rnd_units = RND_W'(cls_r) + RND_W'(1);
  assign rounded   = RND_W'(rnd_units * RND_W'(ALIGN_BYTES));
  assign ep_sum    = end_ptr_r + EP_W'(rounded);
  assign full      = ep_sum > EP_W'(ARENA_BYTES);

  // Link word index: (offset / 4) mod LINK_WORDS by conditional subtracts
  assign link_src = (op_r == scfla_pkg::OP_FREE) ? chunk_r : head_val;
  always_comb begin
    widx_v = CMP_W'(link_src[OFF_W-1:2]);
    for (int k = QSTEPS - 1; k >= 0; k--) begin
      if (widx_v >= (CMP_W'(LINK_WORDS) << k)) begin
        widx_v = widx_v - (CMP_W'(LINK_WORDS) << k);
      end
    end
  end
  assign link_idx = widx_v[LINK_AW-1:0];

  assign head_we    = cmd.push || cmd.pop_wr;
  assign head_wdata = cmd.pop_wr ? link_rdata : chunk_r;

  scfla_ram #(
    .WIDTH (OFF_W),
    .DEPTH (HEAD_DEPTH)
  ) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (cls_r),
    .wdata (head_wdata),
    .re    (cmd.decode),
    .raddr (dec_cls),
    .rdata (head_rdata)
  );

  scfla_ram #(
    .WIDTH (OFF_W),
    .DEPTH (LINK_WORDS)
  ) u_link_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (link_idx),
    .wdata (head_val),
    .re    (cmd.link_rd),
    .raddr (link_idx),
    .rdata (link_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= '0;
      end_ptr_r  <= EP_W'(scfla_pkg::HEADER_BYTES);
    end else begin
      if (head_we) begin
        head_vld_r[cls_r] <= 1'b1;
      end
      if (cmd.bump) begin
        end_ptr_r <= ep_sum;
      end
    end
  end

  always_comb begin
    res_off_nxt = '0;
    res_st_nxt  = scfla_pkg::ST_OK;
    priority if (too_large_r) begin
      res_st_nxt = scfla_pkg::ST_TOO_LARGE;
    end else if (op_r == scfla_pkg::OP_FREE) begin
      res_st_nxt = scfla_pkg::ST_OK;
    end else if (head_val != '0) begin
      res_off_nxt = head_val;
    end else if (full) begin
      res_st_nxt = scfla_pkg::ST_FULL;
    end else begin
      res_off_nxt = end_ptr_r[OFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_off_r <= res_off_nxt;
      res_st_r  <= res_st_nxt;
    end
    if (cmd.load_out) begin
      out_off_r <= res_off_r;
      out_st_r  <= res_st_r;
    end
  end

  assign sts.too_large  = too_large_r;
  assign sts.is_free    = (op_r == scfla_pkg::OP_FREE);
  assign sts.head_empty = (head_val == '0);
  assign sts.full       = full;
  assign sts.chunk_zero = (chunk_r == '0);

  assign out_result_offset = out_off_r;
  assign out_status        = out_st_r;

endmodule

// ===== rtl/size_class_free_list_allocator.sv =====
// Top level of the size-class free-list allocator: controller plus datapath.
// Depends on scfla_pkg, scfla_ctrl, scfla_dp (and scfla_ram through it).
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_op, in_req_size, in_chunk_offset
//   out_     output     out_valid / out_stall out_result_offset, out_status
//
// One request at a time. After acceptance a request passes decode, execute and
// hand-off, with a pop step before hand-off when an allocate pops a list head, since the head RAM
// read and then the link RAM read of that head lie in series.
// The next request is accepted in the cycle after its predecessor's hand-off,
// even while that result still waits in the output register.
// Synchronous active-low reset empties all lists and sets the end pointer to
// 256; link words are not cleared. A stalled output holds back the hand-off.
module size_class_free_list_allocator #(
  parameter int ALIGN_BYTES     = scfla_pkg::ALIGN_BYTES_DEF,
  parameter int MAX_CHUNK_BYTES = scfla_pkg::MAX_CHUNK_BYTES_DEF,
  parameter int ARENA_BYTES     = scfla_pkg::ARENA_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [scfla_pkg::OP_W-1:0]  in_op,
  input  logic [scfla_pkg::REQ_W-1:0] in_req_size,
  input  logic [scfla_pkg::OFF_W-1:0] in_chunk_offset,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [scfla_pkg::OFF_W-1:0] out_result_offset,
  output logic [scfla_pkg::ST_W-1:0]  out_status
);

  scfla_pkg::cmd_t cmd;
  scfla_pkg::sts_t sts;

  scfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  scfla_dp #(
    .ALIGN_BYTES     (ALIGN_BYTES),
    .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES),
    .ARENA_BYTES     (ARENA_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_req_size       (in_req_size),
    .in_chunk_offset   (in_chunk_offset),
    .out_result_offset (out_result_offset),
    .out_status        (out_status)
  );

  // One request in flight: an accepted transaction blocks the input.
  a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a request is in flight");

  // Free-list and end-pointer updates are mutually exclusive.
  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.push, cmd.bump, cmd.link_rd}))
    else $error("conflicting list updates");

  // Output register is never overwritten while a result is pending.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  // Error results carry a zero offset.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == scfla_pkg::ST_TOO_LARGE ||
                   out_status == scfla_pkg::ST_FULL)) |-> (out_result_offset == '0))
    else $error("nonzero offset on error result");

endmodule
